>>> rtl/core/kmd_pkg.sv
`timescale 1ns / 1ps
// kmd_pkg: shared types and constants of the key matrix debouncer.
// No dependencies.
package kmd_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned KEY_MAX  = 8;
    localparam int unsigned DEB_W    = 16;
    localparam logic [DEB_W-1:0] DEB_RESET = 16'd20;

    // register word index on the APB port
    localparam logic REG_DEBOUNCE = 1'b0;

    // per-key state entry held in the key memory
    typedef struct packed {
        logic              raw;
        logic              stable;
        logic [TIME_W-1:0] last_change;
    } t_key_entry;

endpackage

>>> rtl/core/key_matrix_debouncer.sv
`timescale 1ns / 1ps
// key_matrix_debouncer: debounced scan of a ROWS x COLS key matrix.
// Depends on kmd_pkg.
//
// Each request on the slave stream is one scan pass (time stamp in ms and the
// active-low key levels); each pass gives exactly one result with the press-edge
// and the debounced pressed bitmaps. Per-key state (raw level, stable level,
// time of last raw change) sits in a small synchronous memory that is walked
// one key per cycle unless a waiting result stalls it. The next pass is accepted
// at the edge that issues the last key of the previous one, so passes follow
// with no idle cycle; a result is loaded into the output register when the
// last key of its pass is written back. Results are held in that register, so
// scanning goes on while a result waits to be taken, until the next pass
// reaches its last key. After reset all keys are released with a change time
// of zero and the debounce time is 20 ms.
module key_matrix_debouncer
    import kmd_pkg::*;
#(
    parameter int unsigned ROWS = 2,
    parameter int unsigned COLS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] now_ms, [39:32] key_levels
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] press_edges, [15:8] stable_pressed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NKEYS = (ROWS * COLS > KEY_MAX) ? KEY_MAX : ROWS * COLS;
    localparam int unsigned KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;
    localparam logic [KW-1:0] LAST_KEY = KW'(NKEYS - 1);

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [KW-1:0]     key;
        logic              pressed;
        logic [TIME_W-1:0] now;
    } t_stage;

    // configuration
    logic [DEB_W-1:0] r_debounce;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEBOUNCE) ? {16'd0, r_debounce} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEB_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEBOUNCE) begin
            r_debounce <= pwdata[DEB_W-1:0];
        end
    end

    // issue stage
    logic              r_busy;
    logic [KW-1:0]     r_key;
    logic [TIME_W-1:0] r_now;
    logic [NKEYS-1:0]  r_levels;
    t_stage            r_s1;
    logic              stall;
    logic              issue;
    logic              take;

    // output register
    logic        r_ovalid;
    logic [7:0]  r_oedges;
    logic [7:0]  r_ostable;
    logic [7:0]  r_acc_edges;
    logic [7:0]  r_acc_stable;

    assign stall = r_s1.valid && r_s1.last && r_ovalid && !m_axis_tready;
    assign issue = r_busy && !stall;
    assign s_axis_tready = !r_busy || (r_key == LAST_KEY && !stall);
    assign take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_key  <= '0;
        end else if (take) begin
            r_busy <= 1'b1;
            r_key  <= '0;
        end else if (issue) begin
            if (r_key == LAST_KEY) begin
                r_busy <= 1'b0;
            end
            r_key <= r_key + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_now    <= s_axis_tdata[TIME_W-1:0];
            r_levels <= s_axis_tdata[TIME_W +: NKEYS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (!stall) begin
            r_s1.valid <= r_busy;
        end
        if (issue) begin
            r_s1.last    <= (r_key == LAST_KEY);
            r_s1.key     <= r_key;
            r_s1.pressed <= ~r_levels[r_key];
            r_s1.now     <= r_now;
        end
    end

    // key state memory, write-first forwarding on a same-key overlap
    t_key_entry       r_mem [NKEYS];
    logic [NKEYS-1:0] r_vld;
    t_key_entry       r_rd;
    logic             r_rd_vld;
    logic             wr_en;
    t_key_entry       wr_data;
    logic             same;

    assign wr_en = r_s1.valid && !stall;
    assign same  = wr_en && (r_s1.key == r_key);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1.key] <= wr_data;
        end
        if (issue) begin
            r_rd <= same ? wr_data : r_mem[r_key];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_s1.key] <= 1'b1;
            end
            if (issue) begin
                r_rd_vld <= r_vld[r_key] || same;
            end
        end
    end

    // per-key update
    t_key_entry        cur;
    logic [TIME_W-1:0] n_last;
    logic [TIME_W-1:0] age;
    logic              settle;
    logic              n_stable;
    logic              edge_hit;
    logic [7:0]        n_acc_edges;
    logic [7:0]        n_acc_stable;

    always_comb begin
        cur      = r_rd_vld ? r_rd : '0;
        n_last   = (r_s1.pressed != cur.raw) ? r_s1.now : cur.last_change;
        age      = r_s1.now - n_last;
        settle   = age >= {16'd0, r_debounce};
        n_stable = settle ? r_s1.pressed : cur.stable;
        edge_hit = settle && r_s1.pressed && !cur.stable;
        wr_data.raw         = r_s1.pressed;
        wr_data.stable      = n_stable;
        wr_data.last_change = n_last;
        n_acc_edges  = ((r_s1.key == '0) ? 8'd0 : r_acc_edges)
                       | (8'(edge_hit) << r_s1.key);
        n_acc_stable = ((r_s1.key == '0) ? 8'd0 : r_acc_stable)
                       | (8'(n_stable) << r_s1.key);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_acc_edges  <= n_acc_edges;
            r_acc_stable <= n_acc_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (wr_en && r_s1.last) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_s1.last) begin
            r_oedges  <= n_acc_edges;
            r_ostable <= n_acc_stable;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_ostable, r_oedges};

endmodule
